>>> hdl/tdtwp_pkg.sv
// ----------------------------------------------------------------------------
// Turn-drive-turn planner package
// Shared constants, codes, types and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package tdtwp_pkg;

  localparam int SEGMENTS         = 3;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN         = 24;
  localparam int ATAN_IW          = 5;

  localparam int XW = 62;
  localparam int ZW = 36;

  localparam logic [2:0] ACT_GOAL  = 3'd0;
  localparam logic [2:0] ACT_POSE  = 3'd1;
  localparam logic [2:0] ACT_TICK  = 3'd2;
  localparam logic [2:0] ACT_DONE  = 3'd3;
  localparam logic [2:0] ACT_CLEAR = 3'd4;

  localparam logic [1:0] KIND_GOAL     = 2'd0;
  localparam logic [1:0] KIND_WAYPOINT = 2'd1;
  localparam logic [1:0] KIND_FINISHED = 2'd2;

  localparam logic       CFG_POS_MODE = 1'b0;
  localparam logic       CFG_DEADBAND = 1'b1;

  localparam logic signed [17:0]   ANG_PI_Q13  = 18'sd25736;
  localparam logic signed [17:0]   ANG_2PI_Q13 = 18'sd51472;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [ZW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [ZW-1:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [XW-1:0] GAIN_Q30    = 62'sd652032874;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ROT, ST_MIX, ST_GOAL, ST_TICK, ST_ATAN, ST_WRAP, ST_PLAN, ST_EMIT
  } state_t;

  typedef struct packed {
    logic start;
    logic vectoring;
  } cordic_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cordic_sts_t;

  function automatic logic signed [ZW-1:0] atan_q30(input logic [ATAN_IW-1:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:  v = 36'sd843314856;
      5'd1:  v = 36'sd497837829;
      5'd2:  v = 36'sd263043836;
      5'd3:  v = 36'sd133525158;
      5'd4:  v = 36'sd67021686;
      5'd5:  v = 36'sd33543515;
      5'd6:  v = 36'sd16775850;
      5'd7:  v = 36'sd8388437;
      5'd8:  v = 36'sd4194282;
      5'd9:  v = 36'sd2097149;
      5'd10: v = 36'sd1048575;
      5'd11: v = 36'sd524287;
      5'd12: v = 36'sd262143;
      5'd13: v = 36'sd131071;
      5'd14: v = 36'sd65535;
      5'd15: v = 36'sd32767;
      5'd16: v = 36'sd16383;
      5'd17: v = 36'sd8191;
      5'd18: v = 36'sd4095;
      5'd19: v = 36'sd2047;
      5'd20: v = 36'sd1023;
      5'd21: v = 36'sd511;
      5'd22: v = 36'sd255;
      5'd23: v = 36'sd127;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> hdl/tdtwp_cordic.sv
// ----------------------------------------------------------------------------
// Iterative CORDIC unit
// One micro-rotation per cycle; rotation mode gives sin/cos, vectoring mode
// gives atan2. Results hold until the next start.
// ----------------------------------------------------------------------------
module tdtwp_cordic #(
  parameter int CORDIC_STEPS = tdtwp_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  tdtwp_pkg::cordic_req_t               req,
  input  logic signed [tdtwp_pkg::ZW-1:0]      angle,
  input  logic signed [32:0]                   vec_x,
  input  logic signed [32:0]                   vec_y,
  output tdtwp_pkg::cordic_sts_t               sts,
  output logic signed [31:0]                   sin_q30,
  output logic signed [31:0]                   cos_q30,
  output logic signed [tdtwp_pkg::ZW-1:0]      angle_q30
);

  localparam int CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  logic signed [tdtwp_pkg::XW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [tdtwp_pkg::ZW-1:0] z_r, z_nxt;
  logic [CW-1:0]                   cnt_r;
  logic                            busy_r, done_r, neg_r, vec_r;
  logic signed [tdtwp_pkg::XW-1:0] xs, ys, vx_w, vy_w;
  logic signed [tdtwp_pkg::ZW-1:0] at;
  logic [tdtwp_pkg::ATAN_IW-1:0]   idx;
  logic                            up;

  assign idx  = tdtwp_pkg::ATAN_IW'(cnt_r);
  assign at   = tdtwp_pkg::atan_q30(idx);
  assign xs   = x_r >>> idx;
  assign ys   = y_r >>> idx;
  assign up   = vec_r ? !(y_r > 0) : (z_r >= 0);
  assign vx_w = {{(tdtwp_pkg::XW-57){vec_x[32]}}, vec_x, 24'd0};
  assign vy_w = {{(tdtwp_pkg::XW-57){vec_y[32]}}, vec_y, 24'd0};

  always_comb begin
    if (up) begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - at;
    end else begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CW'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      vec_r <= req.vectoring;
      neg_r <= 1'b0;
      if (req.vectoring) begin
        if (vec_x < 0) begin
          x_r <= -vx_w;
          y_r <= -vy_w;
          z_r <= (vec_y >= 0) ? tdtwp_pkg::PI_Q30 : -tdtwp_pkg::PI_Q30;
        end else begin
          x_r <= vx_w;
          y_r <= vy_w;
          z_r <= '0;
        end
      end else begin
        x_r <= tdtwp_pkg::GAIN_Q30;
        y_r <= '0;
        if (angle > tdtwp_pkg::HALF_PI_Q30) begin
          z_r   <= angle - tdtwp_pkg::PI_Q30;
          neg_r <= 1'b1;
        end else if (angle < -tdtwp_pkg::HALF_PI_Q30) begin
          z_r   <= angle + tdtwp_pkg::PI_Q30;
          neg_r <= 1'b1;
        end else begin
          z_r <= angle;
        end
      end
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign sts.busy  = busy_r;
  assign sts.done  = done_r;
  assign sin_q30   = neg_r ? 32'(-y_r) : 32'(y_r);
  assign cos_q30   = neg_r ? 32'(-x_r) : 32'(x_r);
  assign angle_q30 = z_r;

endmodule

>>> hdl/turn_drive_turn_waypoint_planner_core.sv
// ----------------------------------------------------------------------------
// Turn-drive-turn waypoint planner core
// Goal bookkeeping, path building and waypoint sequencing around one CORDIC.
// ----------------------------------------------------------------------------
// Requests enter only while the sequencer is idle. Pose, clear and ignored
// ticks leave it idle. A set-goal request runs sin/cos on the shared CORDIC,
// then four products on one 32x32 multiplier; a planning tick runs atan2 on
// the CORDIC unless the goal is within the deadband; a segment-done request
// goes straight to output. The CORDIC iteration count sets the pace.
// A result waits in an output register while the next request is taken.
module turn_drive_turn_waypoint_planner_core #(
  parameter int CORDIC_STEPS = tdtwp_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // value_x[31:0], value_y[63:32], value_theta[79:64]
  input  logic [2:0]  in_tuser,   // action[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // out_x[31:0], out_y[63:32], out_theta[79:64]
  output logic [1:0]  out_tuser,  // kind[1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int ZW = tdtwp_pkg::ZW;

  tdtwp_pkg::state_t state_r, state_nxt;

  logic               pos_mode_r;
  logic [15:0]        deadband_r;
  logic signed [31:0] goal_x_r, goal_y_r, cur_x_r, cur_y_r;
  logic signed [15:0] goal_h_r;
  logic signed [31:0] wp_x_r [tdtwp_pkg::SEGMENTS];
  logic signed [31:0] wp_y_r [tdtwp_pkg::SEGMENTS];
  logic signed [15:0] wp_h_r [tdtwp_pkg::SEGMENTS];
  logic [1:0]         seg_r;
  logic               computed_r;

  logic [2:0]         act_r;
  logic signed [31:0] vx_r, vy_r, s_r, c_r;
  logic signed [15:0] vt_r, approach_r;
  logic [2:0]         mix_r;
  logic signed [63:0] prod_r;
  logic signed [65:0] accx_r, accy_r;
  logic signed [ZW-1:0] a_r;
  logic               emit_seg_r;

  logic               out_valid_r;
  logic [1:0]         out_kind_r;
  logic signed [31:0] out_x_r, out_y_r;
  logic signed [15:0] out_t_r;

  tdtwp_pkg::cordic_req_t creq;
  tdtwp_pkg::cordic_sts_t csts;
  logic signed [ZW-1:0]   c_angle, c_z;
  logic signed [31:0]     c_sin, c_cos;
  logic signed [32:0]     ex, ey;
  logic signed [33:0]     db;
  logic                   in_band, in_acc, out_free;
  logic signed [31:0]     mul_a, mul_b;
  logic signed [35:0]     dx, dy;
  logic signed [36:0]     nx, ny;
  logic signed [17:0]     h_sum, h_wrap;
  logic signed [ZW-1:0]   a_wrap, a_rnd;

  tdtwp_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (creq),
    .angle     (c_angle),
    .vec_x     (ex),
    .vec_y     (ey),
    .sts       (csts),
    .sin_q30   (c_sin),
    .cos_q30   (c_cos),
    .angle_q30 (c_z)
  );

  assign in_tready = (state_r == tdtwp_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  assign c_angle = {{(ZW-33){goal_h_r[15]}}, goal_h_r, 17'd0};
  assign ex      = 33'(goal_x_r) - 33'(cur_x_r);
  assign ey      = 33'(goal_y_r) - 33'(cur_y_r);
  assign db      = {18'd0, deadband_r};
  assign in_band = (34'(ex) >= -db) && (34'(ex) <= db) &&
                   (34'(ey) >= -db) && (34'(ey) <= db);

  always_comb begin
    case (mix_r)
      3'd0:    begin mul_a = s_r; mul_b = vy_r; end
      3'd1:    begin mul_a = c_r; mul_b = vx_r; end
      3'd2:    begin mul_a = c_r; mul_b = vy_r; end
      default: begin mul_a = s_r; mul_b = vx_r; end
    endcase
  end

  assign dx     = 36'((accx_r + 66'sd536870912) >>> 30);
  assign dy     = 36'((accy_r + 66'sd536870912) >>> 30);
  assign nx     = 37'(goal_x_r) + 37'(dx);
  assign ny     = 37'(goal_y_r) + 37'(dy);
  assign h_sum  = 18'(goal_h_r) + 18'(vt_r);
  assign h_wrap = (h_sum < -tdtwp_pkg::ANG_PI_Q13) ? h_sum + tdtwp_pkg::ANG_2PI_Q13 :
                  (h_sum >  tdtwp_pkg::ANG_PI_Q13) ? h_sum - tdtwp_pkg::ANG_2PI_Q13 : h_sum;
  assign a_wrap = (a_r <= -tdtwp_pkg::PI_Q30) ? a_r + tdtwp_pkg::TWO_PI_Q30 :
                  (a_r >   tdtwp_pkg::PI_Q30) ? a_r - tdtwp_pkg::TWO_PI_Q30 : a_r;
  assign a_rnd  = a_wrap + 36'sd65536;

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    logic signed [31:0] r;
    if (v > 37'sd2147483647)       r = 32'sh7FFFFFFF;
    else if (v < -37'sd2147483648) r = 32'sh80000000;
    else                           r = v[31:0];
    return r;
  endfunction

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tdtwp_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            tdtwp_pkg::ACT_GOAL: state_nxt = tdtwp_pkg::ST_ROT;
            tdtwp_pkg::ACT_TICK:
              if (pos_mode_r && !computed_r) state_nxt = tdtwp_pkg::ST_TICK;
            tdtwp_pkg::ACT_DONE: state_nxt = tdtwp_pkg::ST_EMIT;
            default:             state_nxt = tdtwp_pkg::ST_IDLE;
          endcase
        end
      end
      tdtwp_pkg::ST_ROT:  if (csts.done) state_nxt = tdtwp_pkg::ST_MIX;
      tdtwp_pkg::ST_MIX:  if (mix_r == 3'd4) state_nxt = tdtwp_pkg::ST_GOAL;
      tdtwp_pkg::ST_GOAL: state_nxt = tdtwp_pkg::ST_EMIT;
      tdtwp_pkg::ST_TICK: state_nxt = in_band ? tdtwp_pkg::ST_PLAN : tdtwp_pkg::ST_ATAN;
      tdtwp_pkg::ST_ATAN: if (csts.done) state_nxt = tdtwp_pkg::ST_WRAP;
      tdtwp_pkg::ST_WRAP: state_nxt = tdtwp_pkg::ST_PLAN;
      tdtwp_pkg::ST_PLAN: state_nxt = tdtwp_pkg::ST_EMIT;
      tdtwp_pkg::ST_EMIT: if (out_free) state_nxt = tdtwp_pkg::ST_IDLE;
      default:            state_nxt = tdtwp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    creq.start     = 1'b0;
    creq.vectoring = 1'b0;
    unique case (state_r)
      tdtwp_pkg::ST_IDLE: creq.start = in_acc && (in_tuser == tdtwp_pkg::ACT_GOAL);
      tdtwp_pkg::ST_TICK: begin
        creq.start     = !in_band;
        creq.vectoring = 1'b1;
      end
      default: creq.start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tdtwp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_mode_r <= 1'b0;
      deadband_r <= 16'd655;
    end else if (cfg_valid && cfg_ready && cfg_index[1] == 1'b0) begin
      unique case (cfg_index[0])
        tdtwp_pkg::CFG_POS_MODE: pos_mode_r <= cfg_data[0];
        tdtwp_pkg::CFG_DEADBAND: deadband_r <= cfg_data;
        default:                 pos_mode_r <= pos_mode_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r <= in_tuser;
      vx_r  <= in_tdata[31:0];
      vy_r  <= in_tdata[63:32];
      vt_r  <= in_tdata[79:64];
    end
    if (state_r == tdtwp_pkg::ST_ROT && csts.done) begin
      s_r <= c_sin;
      c_r <= c_cos;
    end
    if (state_r == tdtwp_pkg::ST_ATAN && csts.done) begin
      a_r <= c_z - tdtwp_pkg::HALF_PI_Q30;
    end
    if (state_r == tdtwp_pkg::ST_TICK) begin
      approach_r <= goal_h_r;
    end else if (state_r == tdtwp_pkg::ST_WRAP) begin
      approach_r <= a_rnd[32:17];
    end
    if (state_r == tdtwp_pkg::ST_MIX) begin
      if (mix_r < 3'd4) prod_r <= 64'(mul_a * mul_b);
      if (mix_r == 3'd1 || mix_r == 3'd2) accx_r <= accx_r + 66'(prod_r);
      if (mix_r == 3'd3 || mix_r == 3'd4) accy_r <= accy_r + 66'(prod_r);
    end else begin
      accx_r <= '0;
      accy_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_r <= '0;
    end else if (state_r == tdtwp_pkg::ST_MIX) begin
      mix_r <= mix_r + 1'b1;
    end else begin
      mix_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_x_r   <= '0;
      goal_y_r   <= '0;
      goal_h_r   <= '0;
      cur_x_r    <= '0;
      cur_y_r    <= '0;
      seg_r      <= '0;
      computed_r <= 1'b0;
      emit_seg_r <= 1'b0;
      for (int i = 0; i < tdtwp_pkg::SEGMENTS; i++) begin
        wp_x_r[i] <= '0;
        wp_y_r[i] <= '0;
        wp_h_r[i] <= '0;
      end
    end else begin
      if (in_acc) begin
        emit_seg_r <= (in_tuser != tdtwp_pkg::ACT_GOAL);
        if (in_tuser == tdtwp_pkg::ACT_POSE) begin
          cur_x_r <= in_tdata[31:0];
          cur_y_r <= in_tdata[63:32];
        end else if (in_tuser == tdtwp_pkg::ACT_CLEAR) begin
          goal_x_r   <= '0;
          goal_y_r   <= '0;
          goal_h_r   <= '0;
          cur_x_r    <= '0;
          cur_y_r    <= '0;
          seg_r      <= '0;
          computed_r <= 1'b0;
        end
      end
      if (state_r == tdtwp_pkg::ST_GOAL) begin
        goal_x_r   <= sat32(nx);
        goal_y_r   <= sat32(ny);
        goal_h_r   <= h_wrap[15:0];
        computed_r <= 1'b0;
        seg_r      <= '0;
      end
      if (state_r == tdtwp_pkg::ST_PLAN) begin
        wp_x_r[0]  <= cur_x_r;
        wp_y_r[0]  <= cur_y_r;
        wp_h_r[0]  <= approach_r;
        wp_x_r[1]  <= goal_x_r;
        wp_y_r[1]  <= goal_y_r;
        wp_h_r[1]  <= approach_r;
        wp_x_r[2]  <= goal_x_r;
        wp_y_r[2]  <= goal_y_r;
        wp_h_r[2]  <= goal_h_r;
        computed_r <= 1'b1;
      end
      if (state_r == tdtwp_pkg::ST_EMIT && out_free && emit_seg_r) begin
        seg_r <= (seg_r == 2'(tdtwp_pkg::SEGMENTS)) ? 2'd0 : seg_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == tdtwp_pkg::ST_EMIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == tdtwp_pkg::ST_EMIT && out_free) begin
      if (!emit_seg_r) begin
        out_kind_r <= tdtwp_pkg::KIND_GOAL;
        out_x_r    <= goal_x_r;
        out_y_r    <= goal_y_r;
        out_t_r    <= goal_h_r;
      end else if (seg_r == 2'(tdtwp_pkg::SEGMENTS)) begin
        out_kind_r <= tdtwp_pkg::KIND_FINISHED;
        out_x_r    <= '0;
        out_y_r    <= '0;
        out_t_r    <= '0;
      end else begin
        out_kind_r <= tdtwp_pkg::KIND_WAYPOINT;
        out_x_r    <= wp_x_r[seg_r];
        out_y_r    <= wp_y_r[seg_r];
        out_t_r    <= wp_h_r[seg_r];
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {out_t_r, out_y_r, out_x_r};

`ifndef ASSERT_OFF
  a_cordic_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    csts.done |-> (state_r == tdtwp_pkg::ST_ROT || state_r == tdtwp_pkg::ST_ATAN))
    else $error("cordic finished outside a wait state");
  a_plan_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tdtwp_pkg::ST_PLAN |=> computed_r)
    else $error("path flag not set after planning");
  a_goal_resets_path: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tdtwp_pkg::ST_GOAL |=> (seg_r == 2'd0 && !computed_r))
    else $error("new goal left path state behind");
  a_goal_act_kept: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tdtwp_pkg::ST_MIX |-> act_r == tdtwp_pkg::ACT_GOAL)
    else $error("mixing without a set-goal request");
`endif

endmodule

>>> verif/tb_turn_drive_turn_waypoint_planner_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Turn-drive-turn planner core testbench
// Drives goal, pose, tick, done and clear requests with random gaps and
// output stalls. Every result is checked against a cycle-free planner model
// kept in this file. Directed cases come first, then randomized planning
// sequences under several register settings.
// ----------------------------------------------------------------------------
module tb_turn_drive_turn_waypoint_planner_core;
  import tdtwp_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] x;
    logic [31:0] y;
    logic [15:0] th;
  } plan_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  turn_drive_turn_waypoint_planner_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  localparam longint HALF_PI_L = 64'sd1686629713;
  localparam longint PI_L      = 64'sd3373259426;
  localparam longint TWO_PI_L  = 64'sd6746518852;
  localparam longint GAIN_L    = 64'sd652032874;
  localparam int     STEPS     = 16;

  longint arctan_tbl [0:23] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515, 16775850, 8388437,
    4194282, 2097149, 1048575, 524287, 262143, 131071, 65535, 32767,
    16383, 8191, 4095, 2047, 1023, 511, 255, 127};

  // planner model state
  logic               mode_m;
  logic [15:0]        band_m;
  logic signed [31:0] goal_xm, goal_ym, cur_xm, cur_ym;
  logic signed [15:0] goal_hm;
  logic signed [31:0] wp_xm [0:2];
  logic signed [31:0] wp_ym [0:2];
  logic signed [15:0] wp_hm [0:2];
  int                 seg_m;
  logic               planned_m;

  plan_result_t pending_results [$];
  int  fail_cnt;
  int  sent_cnt;
  int  checked_cnt;
  bit  calm;
  bit  hold_req;
  int  hold_cnt;
  int  stall_cnt;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(20.0 * 3000000);
    $display("timeout at %0t", $time);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic void cordic_sincos(input longint a, output longint s, output longint c);
    longint x, y, z, nx;
    bit neg;
    x = GAIN_L; y = 0; z = a; neg = 0;
    if (z > HALF_PI_L) begin
      z -= PI_L; neg = 1;
    end else if (z < -HALF_PI_L) begin
      z += PI_L; neg = 1;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= arctan_tbl[i];
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += arctan_tbl[i];
      end
      x = nx;
    end
    s = neg ? -y : y;
    c = neg ? -x : x;
  endfunction

  function automatic longint cordic_atan2(input longint yi, input longint xi);
    longint x, y, z, nx;
    x = xi * 64'sd16777216; y = yi * 64'sd16777216; z = 0;
    if (x < 0) begin
      z = (y >= 0) ? PI_L : -PI_L;
      x = -x; y = -y;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); y = y - (x >>> i); z += arctan_tbl[i];
      end else begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= arctan_tbl[i];
      end
      x = nx;
    end
    return z;
  endfunction

  function automatic logic signed [31:0] sat32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic plan_result_t next_segment();
    plan_result_t r;
    if (seg_m >= SEGMENTS) begin
      seg_m = 0;
      r = '{KIND_FINISHED, 32'd0, 32'd0, 16'd0};
    end else begin
      r = '{KIND_WAYPOINT, wp_xm[seg_m], wp_ym[seg_m], wp_hm[seg_m]};
      seg_m = seg_m + 1;
    end
    return r;
  endfunction

  // returns 1 when the request produces a result
  function automatic bit plan_step(input logic [2:0] act, input logic signed [31:0] vx,
                                   input logic signed [31:0] vy, input logic signed [15:0] vt,
                                   output plan_result_t r);
    longint s, c, dx, dy, h, ex, ey, db, a;
    logic signed [15:0] appr;
    r = '0;
    case (act)
      ACT_GOAL: begin
        cordic_sincos(longint'(goal_hm) * 131072, s, c);
        dx = (s * longint'(vy) + c * longint'(vx) + 64'sd536870912) >>> 30;
        dy = (c * longint'(vy) + s * longint'(vx) + 64'sd536870912) >>> 30;
        goal_xm = sat32(longint'(goal_xm) + dx);
        goal_ym = sat32(longint'(goal_ym) + dy);
        h = longint'(goal_hm) + longint'(vt);
        while (h < -25736) h += 51472;
        while (h > 25736) h -= 51472;
        goal_hm = h[15:0];
        planned_m = 0;
        seg_m = 0;
        r = '{KIND_GOAL, goal_xm, goal_ym, goal_hm};
        return 1;
      end
      ACT_POSE: begin
        cur_xm = vx;
        cur_ym = vy;
        return 0;
      end
      ACT_TICK: begin
        if (!mode_m || planned_m) return 0;
        ex = longint'(goal_xm) - longint'(cur_xm);
        ey = longint'(goal_ym) - longint'(cur_ym);
        db = longint'(band_m);
        if (ex >= -db && ex <= db && ey >= -db && ey <= db) begin
          appr = goal_hm;
        end else begin
          a = cordic_atan2(ey, ex) - HALF_PI_L;
          if (a <= -PI_L) a += TWO_PI_L;
          else if (a > PI_L) a -= TWO_PI_L;
          a = (a + 65536) >>> 17;
          appr = a[15:0];
        end
        wp_xm[0] = cur_xm;  wp_ym[0] = cur_ym;  wp_hm[0] = appr;
        wp_xm[1] = goal_xm; wp_ym[1] = goal_ym; wp_hm[1] = appr;
        wp_xm[2] = goal_xm; wp_ym[2] = goal_ym; wp_hm[2] = goal_hm;
        r = next_segment();
        planned_m = 1;
        return 1;
      end
      ACT_DONE: begin
        r = next_segment();
        return 1;
      end
      ACT_CLEAR: begin
        planned_m = 0;
        goal_xm = 0; goal_ym = 0; cur_xm = 0; cur_ym = 0;
        goal_hm = 0;
        seg_m = 0;
        return 0;
      end
      default: return 0;
    endcase
  endfunction

  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] rnd_pos();
    case ($urandom_range(0, 6))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2, 3: return $urandom;
      default: return $urandom_range(0, 2097152) - 1048576;
    endcase
  endfunction

  task automatic send_req(input logic [2:0] act, input logic [31:0] vx,
                          input logic [31:0] vy, input logic [15:0] vt);
    int g;
    plan_result_t r;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {vt, vy, vx};
    do @(posedge clk); while (!in_tready);
    sent_cnt++;
    if (plan_step(act, vx, vy, vt, r)) pending_results.push_back(r);
  endtask

  // hold until every result has come, then let a non-producing request finish
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == 2'(CFG_POS_MODE)) mode_m = val[0];
    else if (idx == 2'(CFG_DEADBAND)) band_m = val;
    @(posedge clk);
  endtask

  task automatic test_directed();
    write_reg(2'(CFG_POS_MODE), 16'd1);
    send_req(ACT_DONE, 0, 0, 0);
    send_req(ACT_TICK, 0, 0, 0);
    send_req(ACT_TICK, 0, 0, 0);
    send_req(ACT_DONE, 0, 0, 0);
    send_req(ACT_DONE, 0, 0, 0);
    send_req(ACT_DONE, 0, 0, 0);
    send_req(ACT_GOAL, 32'h7fffffff, 32'h7fffffff, 16'h7fff);
    send_req(ACT_GOAL, 32'h7fffffff, 32'h7fffffff, 16'h7fff);
    send_req(ACT_DONE, 0, 0, 0);
    send_req(ACT_POSE, 32'h80000000, 32'h80000000, 16'hffff);
    send_req(ACT_TICK, 0, 0, 0);
    send_req(ACT_GOAL, 32'h80000000, 32'h80000000, 16'h8000);
    send_req(ACT_GOAL, 32'h80000000, 32'h00010000, 16'h8000);
    send_req(ACT_TICK, 0, 0, 0);
    send_req(3'd5, 32'hffffffff, 32'hffffffff, 16'hffff);
    send_req(3'd6, 0, 0, 0);
    send_req(3'd7, 0, 0, 0);
    send_req(ACT_CLEAR, 0, 0, 0);
    send_req(ACT_DONE, 0, 0, 0);
    send_req(ACT_TICK, 0, 0, 0);
    send_req(ACT_DONE, 0, 0, 0);
    send_req(ACT_DONE, 0, 0, 0);
    settle();
    write_reg(2'(CFG_POS_MODE), 16'd0);
    send_req(ACT_GOAL, 32'h00030000, 32'hfffd0000, 16'h1000);
    send_req(ACT_TICK, 0, 0, 0);
    send_req(ACT_DONE, 0, 0, 0);
    settle();
  endtask

  task automatic run_sequences(input int count);
    int n;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 9) == 0) calm = ~calm;
      if ($urandom_range(0, 5) == 0) begin
        send_req(3'($urandom), $urandom, $urandom, 16'($urandom));
      end else begin
        send_req(ACT_GOAL, rnd_pos(), rnd_pos(), 16'($urandom));
        if ($urandom_range(0, 2) == 0)
          send_req(ACT_POSE, goal_xm + $urandom_range(0, 1400) - 700,
                   goal_ym + $urandom_range(0, 1400) - 700, 16'($urandom));
        else if ($urandom_range(0, 4) != 0)
          send_req(ACT_POSE, rnd_pos(), rnd_pos(), 16'($urandom));
        send_req(ACT_TICK, $urandom, $urandom, 16'($urandom));
        if ($urandom_range(0, 4) == 0) send_req(ACT_TICK, 0, 0, 0);
        n = $urandom_range(1, 5);
        repeat (n) send_req(ACT_DONE, $urandom, $urandom, 16'($urandom));
        if ($urandom_range(0, 9) == 0) send_req(ACT_CLEAR, $urandom, $urandom, 16'($urandom));
      end
    end
    calm = 0;
    settle();
  endtask

  task automatic test_backpressure();
    hold_req = 1;
    calm = 1;
    repeat (30) send_req(ACT_DONE, 0, 0, 0);
    send_req(ACT_GOAL, rnd_pos(), rnd_pos(), 16'($urandom));
    send_req(ACT_TICK, 0, 0, 0);
    calm = 0;
    settle();
  endtask

  task automatic test_settings();
    write_reg(2'(CFG_POS_MODE), 16'd1);
    write_reg(2'(CFG_DEADBAND), 16'd0);
    run_sequences(55);
    write_reg(2'(CFG_DEADBAND), 16'hffff);
    run_sequences(55);
    write_reg(2'(CFG_DEADBAND), 16'd655);
    run_sequences(55);
    write_reg(2'(CFG_POS_MODE), 16'd0);
    write_reg(2'(CFG_DEADBAND), 16'($urandom));
    run_sequences(40);
    write_reg(2'(CFG_POS_MODE), 16'd1);
    write_reg(2'(CFG_DEADBAND), 16'($urandom));
    run_sequences(100);
  endtask

  // result checker and output stall generator
  always @(posedge clk) begin
    plan_result_t exp_r;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        checked_cnt++;
        if (pending_results.size() == 0) begin
          fail_cnt++;
          $display("%0t unexpected result kind %0d data %h", $time, out_tuser, out_tdata);
        end else begin
          exp_r = pending_results.pop_front();
          if (out_tuser !== exp_r.kind) begin
            fail_cnt++;
            $display("%0t kind exp %0d got %0d", $time, exp_r.kind, out_tuser);
          end
          if (out_tdata[31:0] !== exp_r.x) begin
            fail_cnt++;
            $display("%0t x exp %h got %h", $time, exp_r.x, out_tdata[31:0]);
          end
          if (out_tdata[63:32] !== exp_r.y) begin
            fail_cnt++;
            $display("%0t y exp %h got %h", $time, exp_r.y, out_tdata[63:32]);
          end
          if (out_tdata[79:64] !== exp_r.th) begin
            fail_cnt++;
            $display("%0t theta exp %h got %h", $time, exp_r.th, out_tdata[79:64]);
          end
        end
      end
      if (hold_req) begin
        hold_req = 0;
        hold_cnt = 400;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        out_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < 3) begin
        stall_cnt = $urandom_range(10, 40);
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0; in_tuser = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    fail_cnt = 0; sent_cnt = 0; checked_cnt = 0;
    calm = 0; hold_req = 0; hold_cnt = 0; stall_cnt = 0;
    mode_m = 0; band_m = 16'd655;
    goal_xm = 0; goal_ym = 0; cur_xm = 0; cur_ym = 0; goal_hm = 0;
    for (int i = 0; i < 3; i++) begin
      wp_xm[i] = 0; wp_ym[i] = 0; wp_hm[i] = 0;
    end
    seg_m = 0; planned_m = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_directed();
    test_backpressure();
    test_settings();
    settle();
    $display("covered %0d requests and %0d results over goal, pose, tick, done and clear",
             sent_cnt, checked_cnt);
    $display("register sweeps: position mode on and off, deadband zero, max and random");
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/tdtwp_pkg.sv
hdl/tdtwp_cordic.sv
hdl/turn_drive_turn_waypoint_planner_core.sv
verif/tb_turn_drive_turn_waypoint_planner_core.sv
